@@ hdl/assert_macros.svh @@
// Assertion macros shared by the allocator RTL.
// Plain text macros only; no dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// Next-cycle implication, checked on every rising clock edge outside reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`endif

@@ hdl/pfla_pkg.sv @@
// Shared types, constants and helpers for the page free-list allocator.
// No dependencies.
package pfla_pkg;

   localparam int PAGE_W    = 12;
   localparam int NUM_PAGES = 1 << PAGE_W;
   localparam int LINK_W    = PAGE_W + 1;     // top bit set = end of list
   localparam int COUNT_W   = 13;
   localparam int STEP_W    = PAGE_W + 1;     // holds NUM_PAGES itself
   localparam int STATUS_W  = 2;

   localparam logic [LINK_W-1:0]  LINK_END  = LINK_W'(1) << PAGE_W;
   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
   localparam logic [PAGE_W-1:0]  ANY_PAGE  = '1;
   localparam logic [STEP_W-1:0]  STEP_LAST = STEP_W'(NUM_PAGES);

   typedef enum logic {
      KIND_ALLOC = 1'b0,
      KIND_FREE  = 1'b1
   } kind_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK      = 2'd0,
      STATUS_NO_PAGE = 2'd1,
      STATUS_IGNORED = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_POP,
      ST_WALK,
      ST_UNLINK
   } state_type;

   // Link memory access, one read and/or one write port.
   typedef struct packed {
      logic              wr_en;
      logic [PAGE_W-1:0] wr_addr;
      logic [LINK_W-1:0] wr_data;
      logic              rd_en;
      logic [PAGE_W-1:0] rd_addr;
   } mem_req_type;

   // Finished transaction result from the control unit.
   typedef struct packed {
      logic               valid;
      status_type         status;
      logic [PAGE_W-1:0]  granted_page;
      logic [COUNT_W-1:0] free_pages;
   } result_type;

   function automatic logic page_fits(input logic [PAGE_W-1:0] page,
                                      input logic [PAGE_W-1:0] limit);
      page_fits = (limit == ANY_PAGE) || (page <= limit);
   endfunction

endpackage

@@ hdl/pfla_ifs.sv @@
// Valid/ready channel interfaces for request and response transactions.
// Depends on pfla_pkg.
interface pfla_req_if import pfla_pkg::*; ();
   logic              valid;
   logic              ready;
   logic              kind;
   logic [PAGE_W-1:0] page_number;
   logic [PAGE_W-1:0] max_page;

   modport source (output valid, kind, page_number, max_page, input ready);
   modport sink   (input valid, kind, page_number, max_page, output ready);
endinterface

interface pfla_rsp_if import pfla_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [PAGE_W-1:0]   granted_page;
   logic [COUNT_W-1:0]  free_pages;

   modport source (output valid, status, granted_page, free_pages, input ready);
   modport sink   (input valid, status, granted_page, free_pages, output ready);
endinterface

@@ hdl/pfla_link_ram.sv @@
// Next-link memory: one entry per page, one write and one read port.
// Registered read data. Depends on pfla_pkg.
module pfla_link_ram import pfla_pkg::*; (
   input  logic              clock,
   input  mem_req_type       mem_req,
   output logic [LINK_W-1:0] rd_data
);

   logic [LINK_W-1:0] link_mem [NUM_PAGES];
   logic [LINK_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         link_mem[mem_req.wr_addr] <= mem_req.wr_data;
      end
   end

   // Holds its value while no read is issued.
   always_ff @(posedge clock) begin
      if (mem_req.rd_en) begin
         rd_data_ff <= link_mem[mem_req.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hdl/pfla_ctrl.sv @@
// Allocator control: stack head, free count and the list walk sequencer.
// Depends on pfla_pkg, pfla_ifs, assert_macros.svh.
`include "assert_macros.svh"

module pfla_ctrl import pfla_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   pfla_req_if.sink          req_ch,
   input  logic              out_free,
   output mem_req_type       mem_req,
   input  logic [LINK_W-1:0] rd_data,
   output result_type        result
);

   state_type          state_ff, state_in;
   logic [LINK_W-1:0]  head_ff, head_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [PAGE_W-1:0]  limit_ff, limit_in;
   logic [PAGE_W-1:0]  prev_ff, prev_in;
   logic [PAGE_W-1:0]  cand_ff, cand_in;
   logic [STEP_W-1:0]  step_ff, step_in;

   logic [COUNT_W-1:0] count_inc;
   logic [COUNT_W-1:0] count_dec;
   logic [PAGE_W-1:0]  head_page;
   logic [PAGE_W-1:0]  next_page;
   logic               next_end;

   assign count_inc = (count_ff != COUNT_MAX) ? count_ff + COUNT_W'(1) : count_ff;
   assign count_dec = (count_ff != '0) ? count_ff - COUNT_W'(1) : count_ff;
   assign head_page = head_ff[PAGE_W-1:0];
   assign next_page = rd_data[PAGE_W-1:0];
   assign next_end  = rd_data[LINK_W-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         head_ff  <= LINK_END;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         head_ff  <= head_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      limit_ff <= limit_in;
      prev_ff  <= prev_in;
      cand_ff  <= cand_in;
      step_ff  <= step_in;
   end

   always_comb begin
      state_in            = state_ff;
      head_in             = head_ff;
      count_in            = count_ff;
      limit_in            = limit_ff;
      prev_in             = prev_ff;
      cand_in             = cand_ff;
      step_in             = step_ff;
      mem_req             = '0;
      req_ch.ready        = 1'b0;
      result.valid        = 1'b0;
      result.status       = STATUS_NO_PAGE;
      result.granted_page = '0;
      result.free_pages   = count_ff;

      case (state_ff)
         ST_IDLE: begin
            req_ch.ready = out_free;
            if (req_ch.valid && out_free) begin
               limit_in = req_ch.max_page;
               if (req_ch.kind == KIND_FREE) begin
                  result.valid = 1'b1;
                  if (req_ch.page_number == '0) begin
                     result.status = STATUS_IGNORED;
                  end else begin
                     mem_req.wr_en     = 1'b1;
                     mem_req.wr_addr   = req_ch.page_number;
                     mem_req.wr_data   = head_ff;
                     head_in           = {1'b0, req_ch.page_number};
                     count_in          = count_inc;
                     result.status     = STATUS_OK;
                     result.free_pages = count_inc;
                  end
               end else if (head_ff[LINK_W-1]) begin
                  result.valid = 1'b1;
               end else begin
                  mem_req.rd_en   = 1'b1;
                  mem_req.rd_addr = head_page;
                  prev_in         = head_page;
                  if (page_fits(head_page, req_ch.max_page)) begin
                     state_in = ST_POP;
                  end else begin
                     step_in  = STEP_W'(1);
                     state_in = ST_WALK;
                  end
               end
            end
         end
         ST_POP: begin
            if (out_free) begin
               head_in             = rd_data;
               count_in            = count_dec;
               result.valid        = 1'b1;
               result.status       = STATUS_OK;
               result.granted_page = prev_ff;
               result.free_pages   = count_dec;
               state_in            = ST_IDLE;
            end
         end
         ST_WALK: begin
            if (next_end || (!page_fits(next_page, limit_ff) && step_ff == STEP_LAST)) begin
               // end of list or walk budget spent: fail
               if (out_free) begin
                  result.valid = 1'b1;
                  state_in     = ST_IDLE;
               end
            end else if (page_fits(next_page, limit_ff)) begin
               mem_req.rd_en   = 1'b1;
               mem_req.rd_addr = next_page;
               cand_in         = next_page;
               state_in        = ST_UNLINK;
            end else begin
               mem_req.rd_en   = 1'b1;
               mem_req.rd_addr = next_page;
               prev_in         = next_page;
               step_in         = step_ff + STEP_W'(1);
            end
         end
         ST_UNLINK: begin
            if (out_free) begin
               mem_req.wr_en       = 1'b1;
               mem_req.wr_addr     = prev_ff;
               mem_req.wr_data     = rd_data;
               count_in            = count_dec;
               result.valid        = 1'b1;
               result.status       = STATUS_OK;
               result.granted_page = cand_ff;
               result.free_pages   = count_dec;
               state_in            = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   `ASSERT_IMPL(a_no_rw_overlap, clock, reset, mem_req.wr_en, !mem_req.rd_en)
   `ASSERT_IMPL(a_head_nonzero, clock, reset, !head_ff[LINK_W-1], head_page != '0)
   `ASSERT_IMPL(a_step_bound, clock, reset, state_ff == ST_WALK,
                step_ff != '0 && step_ff <= STEP_LAST)

endmodule

@@ hdl/page_free_list_allocator_core.v.sv @@
// Empty unit kept beside the top level; holds no design code.
// No dependencies.

@@ hdl/page_free_list_allocator_core.sv @@
// Top level of the page free-list allocator: control, link memory, response register.
// Depends on pfla_pkg, pfla_ifs, pfla_link_ram, pfla_ctrl, assert_macros.svh.
//
//   channel  direction  handshake            payload
//   req_ch   in         valid/ready          kind, page_number, max_page
//   rsp_ch   out        valid/ready          status, granted_page, free_pages
//
// Free, ignored free and alloc on an empty list finish in the accepting cycle. Alloc
// popping the head reads the head's link, then grants. Constrained alloc reads one
// link per step of the walk and unlinks on success; the walk stops at the list end or after
// NUM_PAGES links, each one link memory read.
// Reset (synchronous) empties the list and clears the count; the link memory is
// not cleared and needs no pass. One transaction is worked on at a time; a result
// parks in the response register. A full, undrained register holds req_ch ready
// low while idle and holds a finished transaction in its last state until it drains.
`include "assert_macros.svh"

module page_free_list_allocator_core import pfla_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   pfla_req_if.sink   req_ch,
   pfla_rsp_if.source rsp_ch
);

   mem_req_type        mem_req;
   logic [LINK_W-1:0]  rd_data;
   result_type         result;
   logic               out_free;

   logic               rsp_valid_ff;
   status_type         rsp_status_ff;
   logic [PAGE_W-1:0]  rsp_granted_ff;
   logic [COUNT_W-1:0] rsp_count_ff;

   // response register is empty or is being drained this cycle
   assign out_free = !rsp_valid_ff || rsp_ch.ready;

   pfla_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_ch   (req_ch),
      .out_free (out_free),
      .mem_req  (mem_req),
      .rd_data  (rd_data),
      .result   (result)
   );

   pfla_link_ram u_link_ram (
      .clock   (clock),
      .mem_req (mem_req),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (result.valid) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (result.valid) begin
         rsp_status_ff  <= result.status;
         rsp_granted_ff <= result.granted_page;
         rsp_count_ff   <= result.free_pages;
      end
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.status       = rsp_status_ff;
   assign rsp_ch.granted_page = rsp_granted_ff;
   assign rsp_ch.free_pages   = rsp_count_ff;

   `ASSERT_IMPL(a_result_has_room, clock, reset, result.valid, out_free)
   `ASSERT_NEXT(a_free_one_cycle, clock, reset,
                req_ch.valid && req_ch.ready && req_ch.kind == KIND_FREE, rsp_valid_ff)
   `ASSERT_IMPL(a_fail_no_grant, clock, reset,
                rsp_valid_ff && rsp_status_ff != STATUS_OK, rsp_granted_ff == '0)

endmodule

@@ sim/tb_page_free_list_allocator_core.sv @@
`timescale 1ns / 100ps
// Testbench for page_free_list_allocator_core: a mirror of the linked free-page stack
// predicts every response transaction, checked in order. Needs pfla_pkg, pfla_ifs, RTL.
module tb_page_free_list_allocator_core import pfla_pkg::*; ();

   typedef struct {
      status_type         status;
      logic [PAGE_W-1:0]  granted;
      logic [COUNT_W-1:0] free_pages;
   } page_outcome_type;

   // Mirror of head, link memory and count; holds outcomes not yet seen on rsp_ch.
   class free_list_mirror_type;
      logic [LINK_W-1:0]  head;
      logic [LINK_W-1:0]  link_mem [NUM_PAGES];
      logic [COUNT_W-1:0] count;
      bit                 listed [NUM_PAGES];
      page_outcome_type   awaited [$];
      int                 mismatches = 0;
      int                 responses = 0;
      int                 grants = 0;
      int                 no_page = 0;
      int                 ignored = 0;

      function new();
         head  = LINK_END;
         count = '0;
         for (int i = 0; i < NUM_PAGES; i++) begin
            link_mem[i] = LINK_END;
            listed[i]   = 1'b0;
         end
      endfunction

      function bit qualifies(logic [PAGE_W-1:0] page, logic [PAGE_W-1:0] limit);
         return (limit == ANY_PAGE) || (page <= limit);
      endfunction

      // Apply one accepted request and queue the outcome it must produce.
      function void record_request(kind_type kind, logic [PAGE_W-1:0] page,
                                   logic [PAGE_W-1:0] limit);
         page_outcome_type  res;
         logic [PAGE_W-1:0] prev;
         logic [LINK_W-1:0] nxt;
         res.status  = STATUS_NO_PAGE;
         res.granted = '0;
         if (kind == KIND_FREE) begin
            if (page == '0) begin
               res.status = STATUS_IGNORED;
            end else begin
               link_mem[page] = head;
               head           = {1'b0, page};
               listed[page]   = 1'b1;
               if (count != COUNT_MAX) count++;
               res.status = STATUS_OK;
            end
         end else if (!head[PAGE_W]) begin
            if (qualifies(head[PAGE_W-1:0], limit)) begin
               res.granted = head[PAGE_W-1:0];
               head        = link_mem[res.granted];
               res.status  = STATUS_OK;
            end else begin
               // walk budget: NUM_PAGES links, so a looped list ends in a failure
               prev = head[PAGE_W-1:0];
               for (int steps = 0; steps < NUM_PAGES; steps++) begin
                  nxt = link_mem[prev];
                  if (nxt[PAGE_W]) break;
                  if (qualifies(nxt[PAGE_W-1:0], limit)) begin
                     link_mem[prev] = link_mem[nxt[PAGE_W-1:0]];
                     res.granted    = nxt[PAGE_W-1:0];
                     res.status     = STATUS_OK;
                     break;
                  end
                  prev = nxt[PAGE_W-1:0];
               end
            end
            if (res.status == STATUS_OK) begin
               listed[res.granted] = 1'b0;
               if (count != '0) count--;
            end
         end
         res.free_pages = count;
         if (res.status == STATUS_IGNORED) ignored++;
         else if (res.status == STATUS_NO_PAGE) no_page++;
         else if (kind == KIND_ALLOC) grants++;
         awaited.push_back(res);
      endfunction

      task report(string what);
         mismatches++;
         if (mismatches <= 40) $display("mismatch: %s", what);
      endtask

      task check_response(logic [STATUS_W-1:0] status, logic [PAGE_W-1:0] granted,
                          logic [COUNT_W-1:0] free_pages);
         page_outcome_type want;
         responses++;
         if (awaited.size() == 0) begin
            report($sformatf("response %0d arrived with nothing awaited", responses));
            return;
         end
         want = awaited.pop_front();
         if (status !== want.status)
            report($sformatf("response %0d status %0d, want %0d", responses, status,
                             want.status));
         if (granted !== want.granted)
            report($sformatf("response %0d granted_page %0d, want %0d", responses,
                             granted, want.granted));
         if (free_pages !== want.free_pages)
            report($sformatf("response %0d free_pages %0d, want %0d", responses,
                             free_pages, want.free_pages));
      endtask
   endclass

   localparam int RANDOM_ITEMS    = 1100;
   localparam int RSP_HOLD_CYCLES = 400;       // long back-pressure stretch
   localparam int CYCLE_LIMIT     = 3_000_000;
   localparam int TAIL_CYCLES     = 50;
   localparam int BURST_FREES     = 60;

   logic clock = 1'b0;
   logic reset = 1'b1;

   pfla_req_if req_ch ();
   pfla_rsp_if rsp_ch ();

   page_free_list_allocator_core dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   free_list_mirror_type mirror = new();

   // Idle control shared by the two sides.
   bit req_burst        = 1'b0;   // sender runs with no gaps
   bit rsp_burst        = 1'b0;   // receiver runs with no gaps
   bit no_idle          = 1'b0;   // both sides flat out (burst phase)
   bit rsp_hold_request = 1'b0;   // asks the receiver for one long hold-off
   bit rsp_holding      = 1'b0;   // receiver is in that hold-off
   int cycle_count      = 0;

   initial begin
      forever #10 clock = !clock;
   end

   initial begin
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
   end

   // Watchdog: a correct run ends far below this.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   // One request transaction. Starts and ends at a falling edge; valid is only
   // lowered when a gap is drawn, so back-to-back transactions keep it high.
   task automatic send_request(kind_type kind, logic [PAGE_W-1:0] page,
                               logic [PAGE_W-1:0] limit);
      int gap;
      if ($urandom_range(0, 39) == 0) req_burst = !req_burst;
      gap = (no_idle || req_burst || rsp_holding) ? 0 : $urandom_range(0, 15);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_ch.valid       <= 1'b1;
      req_ch.kind        <= kind;
      req_ch.page_number <= page;
      req_ch.max_page    <= limit;
      do @(posedge clock); while (!req_ch.ready);
      mirror.record_request(kind, page, limit);
      @(negedge clock);
   endtask

   // max_page is don't-care on a free, page_number on an allocate: fill with noise.
   task automatic send_free(logic [PAGE_W-1:0] page);
      send_request(KIND_FREE, page, PAGE_W'($urandom));
   endtask

   task automatic send_alloc(logic [PAGE_W-1:0] limit);
      send_request(KIND_ALLOC, PAGE_W'($urandom), limit);
   endtask

   // Sender pause: drops valid, returns at a falling edge once nothing is outstanding.
   task automatic drain_responses();
      req_ch.valid <= 1'b0;
      while (mirror.awaited.size() != 0) @(posedge clock);
      @(negedge clock);
   endtask

   // A page not on the list, so that a free is never a double free.
   function automatic logic [PAGE_W-1:0] pick_unlisted_page(int lo, int hi);
      logic [PAGE_W-1:0] p;
      for (int tries = 0; tries < 1000; tries++) begin
         p = PAGE_W'($urandom_range(hi, lo));
         if (!mirror.listed[p]) return p;
      end
      for (int i = 1; i < NUM_PAGES; i++)
         if (!mirror.listed[i]) return PAGE_W'(i);
      return PAGE_W'(1);
   endfunction

   // Response side: random ready gaps, one long hold-off on request.
   initial begin
      int gap;
      rsp_ch.ready <= 1'b0;
      while (reset) @(negedge clock);
      forever begin
         if (rsp_hold_request) begin
            rsp_hold_request = 1'b0;
            rsp_holding      = 1'b1;
            rsp_ch.ready <= 1'b0;
            repeat (RSP_HOLD_CYCLES) @(negedge clock);
            rsp_holding = 1'b0;
         end else begin
            if ($urandom_range(0, 39) == 0) rsp_burst = !rsp_burst;
            gap = (no_idle || rsp_burst) ? 0 : $urandom_range(0, 15);
            if (gap > 0) begin
               rsp_ch.ready <= 1'b0;
               repeat (gap) @(negedge clock);
            end
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (!rsp_ch.valid);
         mirror.check_response(rsp_ch.status, rsp_ch.granted_page, rsp_ch.free_pages);
         @(negedge clock);
      end
   end

   // Request side: directed, random, then the looped-list and flat-out phase.
   initial begin
      logic [PAGE_W-1:0] page;
      logic [PAGE_W-1:0] limit;
      int                roll;
      int                free_odds;
      int                n;
      req_ch.valid       <= 1'b0;
      req_ch.kind        <= KIND_ALLOC;
      req_ch.page_number <= '0;
      req_ch.max_page    <= '0;
      while (reset) @(negedge clock);

      // --- directed ---
      send_alloc(ANY_PAGE);               // empty list, any limit
      send_alloc('0);                     // empty list, tightest limit
      send_free('0);                      // page zero is ignored
      send_free(ANY_PAGE);                // highest page
      send_free(PAGE_W'(1));              // lowest page
      send_free(PAGE_W'(2048));
      send_free(PAGE_W'(3));
      send_alloc(ANY_PAGE);               // head pop: 3
      send_alloc('0);                     // nothing qualifies, walk to list end
      send_alloc(PAGE_W'(1));             // unlink 1 from the middle
      send_alloc(PAGE_W'(2047));          // 2048 and 4095 both too high
      send_alloc(PAGE_W'(4094));          // head 2048 fits
      send_alloc(PAGE_W'(4094));          // only 4095 left, does not fit
      send_alloc(ANY_PAGE);               // 4095 taken under the any-page limit
      send_free(PAGE_W'(10));
      send_free(PAGE_W'(20));
      send_free(PAGE_W'(30));
      send_alloc(PAGE_W'(10));            // unlink the tail
      send_alloc(PAGE_W'(10));            // tail gone, fails
      send_alloc(PAGE_W'(25));            // unlink 20 below the head
      send_alloc(ANY_PAGE);               // last page
      send_request(KIND_ALLOC, ANY_PAGE, ANY_PAGE);  // page field ignored, list empty
      drain_responses();

      // --- random: list kept short so walks stay cheap, no double frees ---
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (i == 400) rsp_hold_request = 1'b1;   // block fills and stalls req_ch
         if (i == 800) drain_responses();
         roll      = $urandom_range(0, 99);
         free_odds = (mirror.count < 8) ? 75 : (mirror.count > 120) ? 25 : 50;
         if (roll < 3) begin
            send_free('0);
         end else if (roll < free_odds) begin
            if ($urandom_range(0, 4) == 0) page = pick_unlisted_page(1, 63);
            else page = pick_unlisted_page(1, NUM_PAGES - 1);
            send_free(page);
         end else begin
            case ($urandom_range(0, 9))
               0, 1, 2, 3: limit = ANY_PAGE;
               4, 5, 6: begin
                  // limit equal to a listed page: walk reaches deep
                  limit = PAGE_W'($urandom);
                  for (int tries = 0; tries < 10000 && !mirror.listed[limit]; tries++)
                     limit = PAGE_W'($urandom);
               end
               7:       limit = PAGE_W'($urandom);
               8:       limit = PAGE_W'($urandom_range(0, 63));
               default: limit = '0;
            endcase
            send_alloc(limit);
         end
      end

      // --- double free: the page links to itself and the loop never goes away ---
      drain_responses();
      page = pick_unlisted_page(1, NUM_PAGES - 1);
      send_free(page);
      send_free(page);
      repeat (2) send_alloc('0);          // walk runs out its link budget
      n = mirror.count + 3;
      repeat (n) send_alloc(ANY_PAGE);    // count runs down and holds at zero
      repeat (40) begin
         if ($urandom_range(0, 1) == 0) send_free(PAGE_W'($urandom_range(1, 15)));
         else if ($urandom_range(0, 1) == 0) send_alloc(ANY_PAGE);
         else send_alloc(PAGE_W'($urandom_range(0, 20)));
      end

      // --- flat out on both sides ---
      no_idle = 1'b1;
      repeat (BURST_FREES) send_free(PAGE_W'($urandom_range(1, NUM_PAGES - 1)));
      repeat (2) send_alloc(ANY_PAGE);
      repeat (3) send_free(PAGE_W'($urandom_range(1, NUM_PAGES - 1)));
      no_idle = 1'b0;

      drain_responses();
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("%0d transactions checked: %0d grants, %0d failed allocations, %0d ignored",
               mirror.responses, mirror.grants, mirror.no_page, mirror.ignored);
      $display("included a long response stall, a self-linked list, a count held at zero");
      $display("and a back-to-back burst with no idle on either side");
      if (mirror.mismatches == 0 && mirror.awaited.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
